>>> sv/icf_pkg.sv
// ----------------------------------------------------------------------------
// icf_pkg
// Shared constants, types and helpers of the image crossfade sequencer.
// ----------------------------------------------------------------------------
package icf_pkg;

    localparam int MAX_IMAGES = 4;
    localparam int ALPHA_BITS = 8;
    localparam int TIME_BITS  = 16;

    localparam int SLOT_W  = $clog2(MAX_IMAGES);
    localparam int COUNT_W = 3;
    localparam int CHAN_W  = 8;
    localparam int ALPHA_W = ALPHA_BITS + 1;
    localparam int POS_W   = TIME_BITS + 1;
    localparam int CMP_W   = (SLOT_W + 1 > COUNT_W) ? SLOT_W + 1 : COUNT_W;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [TIME_BITS-1:0] HOLD_RST  = TIME_BITS'(1000);
    localparam logic [TIME_BITS-1:0] FADE_RST  = TIME_BITS'(500);
    localparam logic [COUNT_W-1:0]   COUNT_RST = COUNT_W'(4);

    typedef enum logic [1:0] {
        REG_HOLD  = 2'd0,
        REG_FADE  = 2'd1,
        REG_COUNT = 2'd2,
        REG_NONE  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic                  start;
        logic [TIME_BITS-1:0]  dividend;
        logic [TIME_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [ALPHA_BITS-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  image_index;
        logic [SLOT_W-1:0]  following_index;
        logic [ALPHA_W-1:0] fade_alpha;
        logic [CHAN_W-1:0]  red_out;
        logic [CHAN_W-1:0]  green_out;
        logic [CHAN_W-1:0]  blue_out;
    } out_item_t;

    function automatic logic [SLOT_W-1:0] slot_after(
        input logic [SLOT_W-1:0]  slot,
        input logic [COUNT_W-1:0] count
    );
        logic [CMP_W-1:0] live;
        logic [CMP_W-1:0] n;
        begin
            if (count == '0)
            begin
                live = CMP_W'(1);
            end
            else if (CMP_W'(count) > CMP_W'(MAX_IMAGES))
            begin
                live = CMP_W'(MAX_IMAGES);
            end
            else
            begin
                live = CMP_W'(count);
            end
            n = CMP_W'(slot) + CMP_W'(1);
            slot_after = (n >= live) ? '0 : SLOT_W'(n);
        end
    endfunction

endpackage

>>> sv/icf_channels_if.sv
// ----------------------------------------------------------------------------
// icf_channels_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface icf_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [icf_pkg::CHAN_W-1:0]  cur_red;
    logic [icf_pkg::CHAN_W-1:0]  cur_green;
    logic [icf_pkg::CHAN_W-1:0]  cur_blue;
    logic [icf_pkg::CHAN_W-1:0]  next_red;
    logic [icf_pkg::CHAN_W-1:0]  next_green;
    logic [icf_pkg::CHAN_W-1:0]  next_blue;

    modport source (
        output valid, kind, cur_red, cur_green, cur_blue,
               next_red, next_green, next_blue,
        input  ready
    );
    modport sink (
        input  valid, kind, cur_red, cur_green, cur_blue,
               next_red, next_green, next_blue,
        output ready
    );
endinterface

interface icf_out_if;
    logic                        valid;
    logic                        ready;
    logic [icf_pkg::SLOT_W-1:0]  image_index;
    logic [icf_pkg::SLOT_W-1:0]  following_index;
    logic [icf_pkg::ALPHA_W-1:0] fade_alpha;
    logic [icf_pkg::CHAN_W-1:0]  red_out;
    logic [icf_pkg::CHAN_W-1:0]  green_out;
    logic [icf_pkg::CHAN_W-1:0]  blue_out;

    modport source (
        output valid, image_index, following_index, fade_alpha,
               red_out, green_out, blue_out,
        input  ready
    );
    modport sink (
        input  valid, image_index, following_index, fade_alpha,
               red_out, green_out, blue_out,
        output ready
    );
endinterface

>>> sv/image_crossfade_sequencer.sv
// ----------------------------------------------------------------------------
// image_crossfade_sequencer
// Slideshow crossfade engine: tick items step the segment position, image
// slot and alpha, pixel items blend a current and a next RGB pixel.
// ----------------------------------------------------------------------------
// Channels: items (valid/ready) carries kind plus current and next RGB;
// results (valid/ready) carries image index, following index, alpha and the
// blended RGB (zero for tick items). One result per item, in order.
// Configuration: APB write of hold_ticks (0x0), fade_ticks (0x4) and
// image_count (0x8); write only while no item is in flight.
// A pixel item is registered in the blend lanes on acceptance and goes via
// EMIT to the output register; a tick item steps through WRAP, ALPHA, DIV
// (serial divider, one quotient bit per cycle; only when alpha is divided
// out in the fade phase) and EMIT. One item is worked on at a time; items
// is ready again the cycle after the result enters the output register.
// Reset clears position, image slot and alpha, loads the default registers
// and empties the output register. While results stalls the output register
// holds its item; one more item is taken and finished, then waits for room.
// ----------------------------------------------------------------------------
module image_crossfade_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    icf_in_if.sink                      items,
    icf_out_if.source                   results,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [icf_pkg::ADDR_W-1:0]  paddr,
    input  logic [icf_pkg::DATA_W-1:0]  pwdata,
    output logic [icf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int TW = icf_pkg::TIME_BITS;
    localparam int PW = icf_pkg::POS_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WRAP  = 5'b00010,
        S_ALPHA = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [TW-1:0]                   hold_reg;
    logic [TW-1:0]                   fade_reg;
    logic [icf_pkg::COUNT_W-1:0]     count_reg;
    logic [PW-1:0]                   pos_reg, pos_next;
    logic [icf_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic [icf_pkg::ALPHA_W-1:0]     alpha_reg, alpha_next;
    logic                            kind_reg, kind_next;
    logic                            out_valid_reg, out_valid_next;
    icf_pkg::out_item_t              out_reg;
    icf_pkg::out_item_t              merged;
    logic                            out_load;
    logic                            item_take;
    logic                            cfg_write;
    icf_pkg::reg_idx_t               cfg_idx;
    logic [PW-1:0]                   segment;
    icf_pkg::div_req_t               div_req;
    icf_pkg::div_rsp_t               div_rsp;
    logic [icf_pkg::CHAN_W-1:0]      red_mix, green_mix, blue_mix;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = icf_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_idx)
            icf_pkg::REG_HOLD:  prdata = icf_pkg::DATA_W'(hold_reg);
            icf_pkg::REG_FADE:  prdata = icf_pkg::DATA_W'(fade_reg);
            icf_pkg::REG_COUNT: prdata = icf_pkg::DATA_W'(count_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= icf_pkg::HOLD_RST;
            fade_reg  <= icf_pkg::FADE_RST;
            count_reg <= icf_pkg::COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                icf_pkg::REG_HOLD:  hold_reg  <= pwdata[TW-1:0];
                icf_pkg::REG_FADE:  fade_reg  <= pwdata[TW-1:0];
                icf_pkg::REG_COUNT: count_reg <= pwdata[icf_pkg::COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    icf_blend_lane u_lane_red (
        .clk   (clk),
        .load  (item_take && items.kind),
        .cur   (items.cur_red),
        .nxt   (items.next_red),
        .alpha (alpha_reg),
        .mix   (red_mix)
    );

    icf_blend_lane u_lane_green (
        .clk   (clk),
        .load  (item_take && items.kind),
        .cur   (items.cur_green),
        .nxt   (items.next_green),
        .alpha (alpha_reg),
        .mix   (green_mix)
    );

    icf_blend_lane u_lane_blue (
        .clk   (clk),
        .load  (item_take && items.kind),
        .cur   (items.cur_blue),
        .nxt   (items.next_blue),
        .alpha (alpha_reg),
        .mix   (blue_mix)
    );

    icf_alpha_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign items.ready = (state_reg == S_IDLE);
    assign item_take   = items.valid && items.ready;
    assign segment     = {1'b0, hold_reg} + {1'b0, fade_reg};

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        slot_next        = slot_reg;
        alpha_next       = alpha_reg;
        kind_next        = kind_reg;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = TW'(pos_reg - {1'b0, hold_reg});
        div_req.divisor  = fade_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    kind_next = items.kind;
                    if (items.kind)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        pos_next   = pos_reg + PW'(1);
                        state_next = S_WRAP;
                    end
                end
            end
            S_WRAP:
            begin
                if (segment == '0)
                begin
                    pos_next   = '0;
                    slot_next  = '0;
                    alpha_next = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    if (pos_reg >= segment)
                    begin
                        pos_next  = '0;
                        slot_next = icf_pkg::slot_after(slot_reg, count_reg);
                    end
                    state_next = S_ALPHA;
                end
            end
            S_ALPHA:
            begin
                if ((fade_reg == '0) || (pos_reg < {1'b0, hold_reg}))
                begin
                    alpha_next = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    alpha_next = {1'b0, div_rsp.quotient};
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        merged.image_index     = slot_reg;
        merged.following_index = icf_pkg::slot_after(slot_reg, count_reg);
        merged.fade_alpha      = alpha_reg;
        merged.red_out         = kind_reg ? red_mix   : '0;
        merged.green_out       = kind_reg ? green_mix : '0;
        merged.blue_out        = kind_reg ? blue_mix  : '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            slot_reg      <= '0;
            alpha_reg     <= '0;
            kind_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            slot_reg      <= slot_next;
            alpha_reg     <= alpha_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= merged;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.image_index     = out_reg.image_index;
    assign results.following_index = out_reg.following_index;
    assign results.fade_alpha      = out_reg.fade_alpha;
    assign results.red_out         = out_reg.red_out;
    assign results.green_out       = out_reg.green_out;
    assign results.blue_out        = out_reg.blue_out;

endmodule

>>> sv/icf_blend_lane.sv
// ----------------------------------------------------------------------------
// icf_blend_lane
// One color lane: holds a pixel pair and blends it with the current alpha.
// ----------------------------------------------------------------------------
module icf_blend_lane (
    input  logic                         clk,
    input  logic                         load,
    input  logic [icf_pkg::CHAN_W-1:0]   cur,
    input  logic [icf_pkg::CHAN_W-1:0]   nxt,
    input  logic [icf_pkg::ALPHA_W-1:0]  alpha,
    output logic [icf_pkg::CHAN_W-1:0]   mix
);

    localparam int DIFF_W = icf_pkg::CHAN_W + 1;
    localparam int PROD_W = DIFF_W + icf_pkg::ALPHA_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int PAD_W  = SUM_W - icf_pkg::CHAN_W - icf_pkg::ALPHA_BITS;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (icf_pkg::ALPHA_BITS - 1);

    logic [icf_pkg::CHAN_W-1:0]  cur_reg;
    logic [icf_pkg::CHAN_W-1:0]  nxt_reg;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [icf_pkg::ALPHA_W:0] alpha_s;
    logic signed [PROD_W-1:0]    prod;
    logic signed [SUM_W-1:0]     sum;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= cur;
            nxt_reg <= nxt;
        end
    end

    always_comb
    begin
        diff    = $signed({1'b0, nxt_reg}) - $signed({1'b0, cur_reg});
        alpha_s = $signed({1'b0, alpha});
        prod    = diff * alpha_s;
        sum     = $signed({{PAD_W{1'b0}}, cur_reg, {icf_pkg::ALPHA_BITS{1'b0}}})
                + SUM_W'(prod) + $signed(HALF);
        mix     = sum[icf_pkg::ALPHA_BITS +: icf_pkg::CHAN_W];
    end

endmodule

>>> sv/icf_alpha_div.sv
// ----------------------------------------------------------------------------
// icf_alpha_div
// Restoring divider: one quotient bit per cycle of (diff << ALPHA_BITS) / fade.
// ----------------------------------------------------------------------------
module icf_alpha_div (
    input  logic              clk,
    input  logic              rst_n,
    input  icf_pkg::div_req_t req,
    output icf_pkg::div_rsp_t rsp
);

    localparam int TW    = icf_pkg::TIME_BITS;
    localparam int QW    = icf_pkg::ALPHA_BITS;
    localparam int CNT_W = $clog2(QW + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(QW - 1);

    logic [TW-1:0]    rem_reg;
    logic [TW-1:0]    rem_next;
    logic [TW-1:0]    div_reg;
    logic [QW-1:0]    quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic [TW:0]      shifted;
    logic [TW:0]      trial;
    logic             ge;

    always_comb
    begin
        shifted  = {rem_reg, 1'b0};
        trial    = shifted - {1'b0, div_reg};
        ge       = shifted >= {1'b0, div_reg};
        rem_next = ge ? trial[TW-1:0] : shifted[TW-1:0];
        rsp.done     = busy_reg && (cnt_reg == LAST);
        rsp.quotient = {quo_reg[QW-2:0], ge};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend;
            div_reg <= req.divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= rsp.quotient;
        end
    end

endmodule

>>> sv/icf_checker.sv
// ----------------------------------------------------------------------------
// icf_checker
// Port-level checks of the image crossfade sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module icf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [icf_pkg::ALPHA_W-1:0] fade_alpha,
    input logic [icf_pkg::CHAN_W-1:0]  red_out
);

    localparam logic [icf_pkg::ALPHA_W-1:0] ALPHA_ONE =
        icf_pkg::ALPHA_W'(1) << icf_pkg::ALPHA_BITS;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(fade_alpha) && $stable(red_out))
        else $error("result payload changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while previous item in progress");

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fade_alpha <= ALPHA_ONE)
        else $error("alpha beyond full scale");

endmodule

bind image_crossfade_sequencer icf_checker u_icf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (items.valid),
    .in_ready   (items.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .fade_alpha (results.fade_alpha),
    .red_out    (results.red_out)
);
